@@ hw/rtl/drp_pkg.sv @@
// shared types, codes and defaults for the defaults record parser
`timescale 1ns / 1ps

package drp_pkg;

    // default sizes of the record blocks
    localparam int MAX_OPCODES_DEF  = 16;
    localparam int SPRITE_COUNT_DEF = 11;
    localparam int RAMP_ROWS_DEF    = 3;
    localparam int RAMP_STOPS_DEF   = 5;
    localparam int MODEL_COUNT_DEF  = 2;

    // field widths
    localparam int OPCNT_W = 5;
    localparam int ELEM_W  = 5;
    localparam int OUT_TDATA_W = 40;

    // result kinds
    localparam logic [2:0] KIND_OPCODE  = 3'd0;
    localparam logic [2:0] KIND_LEGACY  = 3'd1;
    localparam logic [2:0] KIND_SPRITE  = 3'd2;
    localparam logic [2:0] KIND_TRAILER = 3'd3;
    localparam logic [2:0] KIND_RAMP    = 3'd4;
    localparam logic [2:0] KIND_MODEL   = 3'd5;
    localparam logic [2:0] KIND_STATUS  = 3'd6;

    // record status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_TRUNC    = 3'd1;
    localparam logic [2:0] ST_TOO_MANY = 3'd2;
    localparam logic [2:0] ST_UNKNOWN  = 3'd3;
    localparam logic [2:0] ST_SECOND   = 3'd4;
    localparam logic [2:0] ST_TRAILING = 3'd5;

    // opcodes
    localparam logic [7:0] OP_END    = 8'd0;
    localparam logic [7:0] OP_LEGACY = 8'd1;
    localparam logic [7:0] OP_SPRITE = 8'd2;
    localparam logic [7:0] OP_RAMP   = 8'd3;
    localparam logic [7:0] OP_MODEL  = 8'd5;
    localparam logic [7:0] OP_SPRTRL = 8'd6;

    // id decoding constants
    localparam logic [31:0] LOW31_MASK = 32'h7FFF_FFFF;
    localparam logic [15:0] SHORT_NONE = 16'd32767;

    // one result item
    typedef struct packed {
        logic        fin;
        logic [2:0]  status;
        logic [31:0] value;
        logic [3:0]  slot;
        logic [2:0]  kind;
    } result_t;

endpackage

@@ hw/rtl/drp_parser.sv @@
// record parser state machine: one byte per step, at most one result
`timescale 1ns / 1ps

module drp_parser
    import drp_pkg::*;
#(
    parameter int MAX_OPCODES  = MAX_OPCODES_DEF,
    parameter int SPRITE_COUNT = SPRITE_COUNT_DEF,
    parameter int RAMP_ROWS    = RAMP_ROWS_DEF,
    parameter int RAMP_STOPS   = RAMP_STOPS_DEF,
    parameter int MODEL_COUNT  = MODEL_COUNT_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  logic [7:0]   data_byte,
    input  logic         last_byte,
    output logic         res_valid,
    output result_t      res
);

    localparam logic [1:0] PH_OPCODE  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_AFTER   = 2'd2;
    localparam logic [1:0] PH_HALTED  = 2'd3;

    localparam logic [ELEM_W-1:0] LEN_SPRITE  = ELEM_W'(SPRITE_COUNT);
    localparam logic [ELEM_W-1:0] LEN_SPRTRL  = ELEM_W'(SPRITE_COUNT + 1);
    localparam logic [ELEM_W-1:0] LEN_RAMP    = ELEM_W'(RAMP_ROWS * RAMP_STOPS);
    localparam logic [ELEM_W-1:0] LEN_MODEL   = ELEM_W'(MODEL_COUNT);
    localparam logic [OPCNT_W-1:0] OPCNT_MAX  = OPCNT_W'(MAX_OPCODES);

    logic [1:0]         phase_reg, phase_next;
    logic [2:0]         op_reg, op_next;
    logic [ELEM_W-1:0]  elem_reg, elem_next;
    logic [1:0]         bidx_reg, bidx_next;
    logic [31:0]        acc_reg, acc_next;
    logic               wide_reg, wide_next;
    logic [OPCNT_W-1:0] opcnt_reg, opcnt_next;
    logic               sprite_reg, sprite_next;
    logic [2:0]         err_reg, err_next;

    logic               known;
    logic               is_sprite_op;
    logic               wide_cur;
    logic [31:0]        acc_cur;
    logic [2:0]         fbytes;
    logic [ELEM_W-1:0]  blk_len;
    logic [ELEM_W-1:0]  elem_inc;
    logic [31:0]        id_val;
    logic [2:0]         fin_status;

    // opcode classification
    always_comb
    begin
        known = (data_byte == OP_LEGACY) || (data_byte == OP_SPRITE) ||
                (data_byte == OP_RAMP) || (data_byte == OP_MODEL) ||
                (data_byte == OP_SPRTRL);
        is_sprite_op = (data_byte == OP_SPRITE) || (data_byte == OP_SPRTRL);
    end

    // payload field assembly
    always_comb
    begin
        wide_cur = (bidx_reg == 2'd0) ? data_byte[7] : wide_reg;
        acc_cur  = {acc_reg[23:0], data_byte};
        case (op_reg)
            OP_LEGACY[2:0], OP_RAMP[2:0]: fbytes = 3'd3;
            OP_MODEL[2:0]:                fbytes = 3'd4;
            default:                      fbytes = wide_cur ? 3'd4 : 3'd2;
        endcase
        case (op_reg)
            OP_LEGACY[2:0]: blk_len = ELEM_W'(1);
            OP_SPRITE[2:0]: blk_len = LEN_SPRITE;
            OP_RAMP[2:0]:   blk_len = LEN_RAMP;
            OP_MODEL[2:0]:  blk_len = LEN_MODEL;
            default:        blk_len = LEN_SPRTRL;
        endcase
        elem_inc = elem_reg + ELEM_W'(1);
        if (wide_cur)
            id_val = acc_cur & LOW31_MASK;
        else if (acc_cur[15:0] == SHORT_NONE)
            id_val = 32'hFFFF_FFFF;
        else
            id_val = {16'd0, acc_cur[15:0]};
    end

    // status reported on the last byte of a record
    always_comb
    begin
        if (phase_reg == PH_HALTED)
            fin_status = err_reg;
        else if (phase_reg == PH_AFTER)
            fin_status = ST_TRAILING;
        else if (phase_reg == PH_PAYLOAD)
            fin_status = ST_TRUNC;
        else if (data_byte == OP_END)
            fin_status = ST_OK;
        else if (opcnt_reg >= OPCNT_MAX)
            fin_status = ST_TOO_MANY;
        else if (!known)
            fin_status = ST_UNKNOWN;
        else if (is_sprite_op && sprite_reg)
            fin_status = ST_SECOND;
        else
            fin_status = ST_TRUNC;
    end

    // next state and result for the byte in hand
    always_comb
    begin
        phase_next  = phase_reg;
        op_next     = op_reg;
        elem_next   = elem_reg;
        bidx_next   = bidx_reg;
        acc_next    = acc_reg;
        wide_next   = wide_reg;
        opcnt_next  = opcnt_reg;
        sprite_next = sprite_reg;
        err_next    = err_reg;
        res_valid   = 1'b0;
        res         = '0;

        if (last_byte)
        begin
            res_valid   = 1'b1;
            res.kind    = KIND_STATUS;
            res.status  = fin_status;
            res.fin     = 1'b1;
            phase_next  = PH_OPCODE;
            op_next     = 3'd0;
            elem_next   = '0;
            bidx_next   = 2'd0;
            acc_next    = '0;
            wide_next   = 1'b0;
            opcnt_next  = '0;
            sprite_next = 1'b0;
            err_next    = ST_OK;
        end
        else
        begin
            case (phase_reg)
                PH_AFTER:
                begin
                    err_next   = ST_TRAILING;
                    phase_next = PH_HALTED;
                end
                PH_OPCODE:
                begin
                    if (data_byte == OP_END)
                        phase_next = PH_AFTER;
                    else if (opcnt_reg >= OPCNT_MAX)
                    begin
                        err_next   = ST_TOO_MANY;
                        phase_next = PH_HALTED;
                    end
                    else if (!known)
                    begin
                        err_next   = ST_UNKNOWN;
                        phase_next = PH_HALTED;
                    end
                    else if (is_sprite_op && sprite_reg)
                    begin
                        err_next   = ST_SECOND;
                        phase_next = PH_HALTED;
                    end
                    else
                    begin
                        res_valid  = 1'b1;
                        res.kind   = KIND_OPCODE;
                        res.slot   = opcnt_reg[3:0];
                        res.value  = {24'd0, data_byte};
                        opcnt_next = opcnt_reg + OPCNT_W'(1);
                        op_next    = data_byte[2:0];
                        if (is_sprite_op)
                            sprite_next = 1'b1;
                        elem_next  = '0;
                        bidx_next  = 2'd0;
                        acc_next   = '0;
                        wide_next  = 1'b0;
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    wide_next = wide_cur;
                    acc_next  = acc_cur;
                    if (({1'b0, bidx_reg} + 3'd1) < fbytes)
                        bidx_next = bidx_reg + 2'd1;
                    else
                    begin
                        res_valid = 1'b1;
                        res.slot  = elem_reg[3:0];
                        res.value = acc_cur;
                        case (op_reg)
                            OP_LEGACY[2:0]:
                            begin
                                res.kind = KIND_LEGACY;
                                res.slot = 4'd0;
                            end
                            OP_RAMP[2:0]:  res.kind = KIND_RAMP;
                            OP_MODEL[2:0]: res.kind = KIND_MODEL;
                            default:
                            begin
                                res.value = id_val;
                                if (op_reg == OP_SPRTRL[2:0] && elem_reg >= LEN_SPRITE)
                                begin
                                    res.kind = KIND_TRAILER;
                                    res.slot = 4'd0;
                                end
                                else
                                    res.kind = KIND_SPRITE;
                            end
                        endcase
                        bidx_next = 2'd0;
                        acc_next  = '0;
                        wide_next = 1'b0;
                        if (elem_inc >= blk_len)
                        begin
                            elem_next  = '0;
                            phase_next = PH_OPCODE;
                        end
                        else
                            elem_next = elem_inc;
                    end
                end
                default:
                begin
                    phase_next = PH_HALTED;
                end
            endcase
        end
    end

    // parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_OPCODE;
            op_reg     <= 3'd0;
            elem_reg   <= '0;
            bidx_reg   <= 2'd0;
            acc_reg    <= '0;
            wide_reg   <= 1'b0;
            opcnt_reg  <= '0;
            sprite_reg <= 1'b0;
            err_reg    <= ST_OK;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            op_reg     <= op_next;
            elem_reg   <= elem_next;
            bidx_reg   <= bidx_next;
            acc_reg    <= acc_next;
            wide_reg   <= wide_next;
            opcnt_reg  <= opcnt_next;
            sprite_reg <= sprite_next;
            err_reg    <= err_next;
        end
    end

endmodule

@@ hw/rtl/drp_result_fifo.sv @@
// two-entry result buffer between the parser and the output channel
`timescale 1ns / 1ps

module drp_result_fifo
    import drp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    room,
    input  logic    pop,
    output logic    not_empty,
    output result_t head
);

    result_t    mem_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] cnt_reg;
    logic       do_pop;

    assign room      = (cnt_reg != 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head      = mem_reg[rptr_reg];
    assign do_pop    = pop && not_empty;

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= push_data;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wptr_reg <= ~wptr_reg;
            if (do_pop)
                rptr_reg <= ~rptr_reg;
            if (push && !do_pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (!push && do_pop)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

endmodule

@@ hw/rtl/defaults_record_parser_unit.sv @@
// top level of the defaults record parser
`timescale 1ns / 1ps
//
// Usage: record bytes arrive on the s_ channel, one byte per transaction,
// with s_tlast on the final byte of the record. Each transaction moves the
// byte into an input register; from there the parser state machine consumes
// it when the buffer has room and writes at most one result into a
// two-entry buffer that drives the m_ channel. Results carry their kind on
// m_tuser and the slot, value and status on m_tdata; m_tlast marks the final
// status of a record. A byte waits in the input register and its result
// in the buffer before appearing on m_tvalid. Throughput: one byte per cycle
// while m_tready stays high, set by the parser step between input register
// and buffer. When the receiver stalls, the buffer fills and then the input
// register holds its byte, dropping s_tready; nothing is lost or repeated.
// Reset clears the parse state, empties the buffer and the input register;
// the next byte is taken as the opcode of a new record.
// A record that fails is reported only by its final status; fields emitted
// before the failure stay emitted and the consumer discards them.

module defaults_record_parser_unit
    import drp_pkg::*;
#(
    parameter int MAX_OPCODES  = MAX_OPCODES_DEF,
    parameter int SPRITE_COUNT = SPRITE_COUNT_DEF,
    parameter int RAMP_ROWS    = RAMP_ROWS_DEF,
    parameter int RAMP_STOPS   = RAMP_STOPS_DEF,
    parameter int MODEL_COUNT  = MODEL_COUNT_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] data_byte
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [3:0] slot, [35:4] value, [38:36] status, pad
    output logic [2:0]             m_tuser,   // [2:0] kind
    output logic                   m_tlast
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       fire;
    logic       room;
    logic       res_valid;
    result_t    res;
    result_t    head;

    // input stage advances when the buffer has space
    assign fire     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || fire;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // parser step
    drp_parser #(
        .MAX_OPCODES  (MAX_OPCODES),
        .SPRITE_COUNT (SPRITE_COUNT),
        .RAMP_ROWS    (RAMP_ROWS),
        .RAMP_STOPS   (RAMP_STOPS),
        .MODEL_COUNT  (MODEL_COUNT)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (fire),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // result buffer
    drp_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire && res_valid),
        .push_data (res),
        .room      (room),
        .pop       (m_tready),
        .not_empty (m_tvalid),
        .head      (head)
    );

    // output packing
    assign m_tdata = {1'b0, head.status, head.value, head.slot};
    assign m_tuser = head.kind;
    assign m_tlast = head.fin;

endmodule

@@ hw/rtl/drp_checker.sv @@
// port-level checks for the defaults record parser, bound to the top level
`timescale 1ns / 1ps

module drp_checker
    import drp_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic [2:0]             m_tuser,
    input logic                   m_tlast
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // only the final status ends a record
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser == KIND_STATUS)
        else $error("record end on a non-status result");

    // field results carry no status
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata[38:36] == ST_OK && m_tuser != KIND_STATUS)
        else $error("status on a field result");

    // an opcode result names a known opcode
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_OPCODE |->
            m_tdata[35:4] == 32'd1 || m_tdata[35:4] == 32'd2 ||
            m_tdata[35:4] == 32'd3 || m_tdata[35:4] == 32'd5 ||
            m_tdata[35:4] == 32'd6)
        else $error("opcode result with an unknown opcode");

endmodule

bind defaults_record_parser_unit drp_checker u_drp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
